@@ src/cmwc_pkg.sv @@
package cmwc_pkg;

  localparam int unsigned LagDepth  = 4096;
  localparam int unsigned MaxWeight = 256;

  localparam logic [14:0] MulA      = 15'd18782;
  localparam logic [31:0] XorBase   = 32'hffff_fffe;
  localparam logic [31:0] LcgMul    = 32'd1103515245;
  localparam logic [31:0] LcgAdd    = 32'd12345;
  localparam logic [31:0] CarryMod  = 32'd809430660;
  localparam logic [31:0] FullSpan  = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OpSeed     = 2'd0,
    OpRaw      = 2'd1,
    OpRange    = 2'd2,
    OpWeighted = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] seed_word;
    logic [31:0] low_bound;
    logic [31:0] high_bound;
    logic [31:0] target_value;
    logic [8:0]  weight_count;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        weight_error;
  } rsp_t;

  typedef enum logic [3:0] {
    CmdNone,
    CmdLoad,
    CmdSeedStep,
    CmdSeedWrite,
    CmdCarryStart,
    CmdCarrySub,
    CmdDrawRead,
    CmdDrawMul,
    CmdDrawWrite,
    CmdDivStart,
    CmdDivStep,
    CmdCompare
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic seed_last;
    logic carry_done;
    logic div_done;
    logic draws_done;
    logic is_range;
  } stat_t;

endpackage

@@ src/cmwc_if.sv @@
interface cmwc_req_if;
  logic           valid;
  logic           ready;
  cmwc_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cmwc_rsp_if;
  logic           valid;
  logic           ready;
  cmwc_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/cmwc_datapath.sv @@
module cmwc_datapath #(
  parameter int unsigned LagDepth  = cmwc_pkg::LagDepth,
  parameter int unsigned MaxWeight = cmwc_pkg::MaxWeight
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmwc_pkg::ctrl_t ctrl_i,
  input  cmwc_pkg::req_t  req_i,
  output cmwc_pkg::stat_t stat_o,
  output cmwc_pkg::rsp_t  rsp_o
);

  localparam int unsigned IdxW = $clog2(LagDepth);
  localparam int unsigned WW   = $clog2(MaxWeight + 1);

  logic [31:0] mem_q [LagDepth];
  logic [31:0] rd_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW:0]   seed_cnt_q;
  logic [31:0] carry_q, s_q, s_next;
  logic [31:0] lo_q, span_q, tgt_q, best_q, x_q;
  logic [WW-1:0] wcnt_q;
  logic        err_q, first_q, range_q;
  logic [31:0] rem_q;
  logic [5:0]  dstep_q;
  logic [46:0] t_full;
  logic [31:0] t_hi, t_lo, x_sum, x_fin, c_fin;
  logic [32:0] rem_sh;
  logic [31:0] cand, d_new, d_best;
  logic [31:0] lo_in, hi_in, span_in;
  logic [8:0]  w_in;

  always_comb begin
    lo_in = req_i.low_bound;
    hi_in = req_i.high_bound;
    if (req_i.low_bound > req_i.high_bound) begin
      lo_in = req_i.high_bound;
      hi_in = req_i.low_bound;
    end
    span_in = hi_in - lo_in + 32'd1;
    if (span_in == 32'd0) begin
      span_in = cmwc_pkg::FullSpan;
    end
    w_in = req_i.weight_count;
    if (w_in == 9'd0) begin
      w_in = 9'd1;
    end
    if (32'(w_in) > MaxWeight) begin
      w_in = 9'(MaxWeight);
    end
  end

  always_comb begin
    t_full = 47'(rd_q) * 47'(cmwc_pkg::MulA) + 47'(carry_q);
    t_hi   = {17'd0, t_full[46:32]};
    t_lo   = t_full[31:0];
    x_sum  = t_lo + t_hi;
    x_fin  = x_sum;
    c_fin  = t_hi;
    if (x_sum < t_hi) begin
      x_fin = x_sum + 32'd1;
      c_fin = t_hi + 32'd1;
    end
  end

  assign s_next = s_q * cmwc_pkg::LcgMul + cmwc_pkg::LcgAdd;
  assign rem_sh = {rem_q, x_q[31]};
  assign cand   = rem_q + lo_q;
  assign d_new  = (cand > tgt_q) ? cand - tgt_q : tgt_q - cand;
  assign d_best = (best_q > tgt_q) ? best_q - tgt_q : tgt_q - best_q;

  always_comb begin
    idx_d = idx_q + IdxW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == cmwc_pkg::CmdSeedWrite) begin
      mem_q[seed_cnt_q[IdxW-1:0]] <= s_q;
    end else if (ctrl_i.cmd == cmwc_pkg::CmdDrawWrite) begin
      mem_q[idx_q] <= x_q;
    end
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      carry_q    <= '0;
      seed_cnt_q <= '0;
      wcnt_q     <= '0;
      dstep_q    <= '0;
      first_q    <= 1'b0;
      err_q      <= 1'b0;
      range_q    <= 1'b0;
      s_q        <= '0;
      lo_q       <= '0;
      span_q     <= '0;
      tgt_q      <= '0;
      best_q     <= '0;
      x_q        <= '0;
      rem_q      <= '0;
    end else begin
      unique case (ctrl_i.cmd)
        cmwc_pkg::CmdLoad: begin
          s_q        <= req_i.seed_word;
          seed_cnt_q <= '0;
          lo_q       <= lo_in;
          span_q     <= span_in;
          tgt_q      <= req_i.target_value;
          range_q    <= (req_i.op != cmwc_pkg::OpRaw);
          err_q      <= (req_i.op == cmwc_pkg::OpWeighted) && (req_i.weight_count == 9'd0);
          wcnt_q     <= (req_i.op == cmwc_pkg::OpWeighted) ? WW'(w_in) : WW'(1);
          first_q    <= 1'b1;
          idx_q      <= idx_d;
        end
        cmwc_pkg::CmdSeedStep: begin
          s_q <= s_next;
        end
        cmwc_pkg::CmdSeedWrite: begin
          seed_cnt_q <= seed_cnt_q + (IdxW+1)'(1);
        end
        cmwc_pkg::CmdCarryStart: begin
          s_q   <= s_next;
          idx_q <= '0;
        end
        cmwc_pkg::CmdCarrySub: begin
          if (s_q >= cmwc_pkg::CarryMod) begin
            s_q <= s_q - cmwc_pkg::CarryMod;
          end else begin
            carry_q <= s_q;
          end
        end
        cmwc_pkg::CmdDrawRead: begin
        end
        cmwc_pkg::CmdDrawMul: begin
          carry_q <= c_fin;
          x_q     <= cmwc_pkg::XorBase - x_fin;
        end
        cmwc_pkg::CmdDrawWrite: begin
          wcnt_q <= wcnt_q - WW'(1);
        end
        cmwc_pkg::CmdDivStart: begin
          rem_q   <= '0;
          dstep_q <= '0;
        end
        cmwc_pkg::CmdDivStep: begin
          if (rem_sh >= {1'b0, span_q}) begin
            rem_q <= 32'(rem_sh - {1'b0, span_q});
          end else begin
            rem_q <= rem_sh[31:0];
          end
          x_q     <= {x_q[30:0], 1'b0};
          dstep_q <= dstep_q + 6'd1;
        end
        cmwc_pkg::CmdCompare: begin
          if (range_q) begin
            if (first_q || d_new < d_best) begin
              best_q <= cand;
            end
          end else begin
            best_q <= x_q;
          end
          first_q <= 1'b0;
          if (wcnt_q != '0) begin
            idx_q <= idx_d;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.seed_last  = (seed_cnt_q == (IdxW+1)'(LagDepth - 1));
  assign stat_o.carry_done = (s_q < cmwc_pkg::CarryMod);
  assign stat_o.div_done   = (dstep_q == 6'd31);
  assign stat_o.draws_done = (wcnt_q == '0);
  assign stat_o.is_range   = range_q;
  assign rsp_o.value        = best_q;
  assign rsp_o.weight_error = err_q;

endmodule

@@ src/cmwc_ctrl.sv @@
module cmwc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_op_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  cmwc_pkg::stat_t stat_i,
  output cmwc_pkg::ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    StIdle, StSeedStep, StSeedWrite, StCarryStep, StCarryDiv, StRead, StReadWait,
    StMul, StWrite, StDivInit, StDiv, StCmp, StOut
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctrl_o.cmd = cmwc_pkg::CmdNone;
    unique case (state_q)
      StIdle:      if (in_valid_i && in_ready_o) ctrl_o.cmd = cmwc_pkg::CmdLoad;
      StSeedStep:  ctrl_o.cmd = cmwc_pkg::CmdSeedStep;
      StSeedWrite: ctrl_o.cmd = cmwc_pkg::CmdSeedWrite;
      StCarryStep: ctrl_o.cmd = cmwc_pkg::CmdCarryStart;
      StCarryDiv:  ctrl_o.cmd = cmwc_pkg::CmdCarrySub;
      StRead:      ctrl_o.cmd = cmwc_pkg::CmdDrawRead;
      StReadWait:  ctrl_o.cmd = cmwc_pkg::CmdNone;
      StMul:       ctrl_o.cmd = cmwc_pkg::CmdDrawMul;
      StWrite:     ctrl_o.cmd = cmwc_pkg::CmdDrawWrite;
      StDivInit:   ctrl_o.cmd = cmwc_pkg::CmdDivStart;
      StDiv:       ctrl_o.cmd = cmwc_pkg::CmdDivStep;
      StCmp:       ctrl_o.cmd = cmwc_pkg::CmdCompare;
      StOut:       ctrl_o.cmd = cmwc_pkg::CmdNone;
      default:     ctrl_o.cmd = cmwc_pkg::CmdNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            state_q <= (in_op_i == cmwc_pkg::OpSeed) ? StSeedStep : StRead;
          end
        end
        StSeedStep:  state_q <= StSeedWrite;
        StSeedWrite: state_q <= stat_i.seed_last ? StCarryStep : StSeedStep;
        StCarryStep: state_q <= StCarryDiv;
        StCarryDiv:  state_q <= stat_i.carry_done ? StIdle : StCarryDiv;
        StRead:      state_q <= StReadWait;
        StReadWait:  state_q <= StMul;
        StMul:       state_q <= StWrite;
        StWrite:     state_q <= stat_i.is_range ? StDivInit : StCmp;
        StDivInit:   state_q <= StDiv;
        StDiv:       state_q <= stat_i.div_done ? StCmp : StDiv;
        StCmp:       state_q <= stat_i.draws_done ? StOut : StRead;
        StOut: begin
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o) else $error("accept while result pending");
`endif

endmodule

@@ src/cmwc_random_range_generator.sv @@
// CMWC4096 random generator. A seed transaction steps and writes each table
// word through the lag memory, then runs up to six compare-and-subtract
// steps for the carry, and returns nothing. A raw draw does a table read,
// multiply, write-back and compare; a range draw adds a bit-serial remainder;
// a weighted draw repeats the range draw for each compared value. One
// transaction is in work at a time.
module cmwc_random_range_generator #(
  parameter int unsigned LagDepth  = cmwc_pkg::LagDepth,
  parameter int unsigned MaxWeight = cmwc_pkg::MaxWeight
) (
  input logic        clk_i,
  input logic        rst_ni,
  cmwc_req_if.sink   req,
  cmwc_rsp_if.source rsp
);

  cmwc_pkg::ctrl_t ctrl;
  cmwc_pkg::stat_t stat;

  cmwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_op_i    (req.payload.op),
    .in_ready_o (req.ready),
    .out_valid_o(rsp.valid),
    .out_ready_i(rsp.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  cmwc_datapath #(
    .LagDepth (LagDepth),
    .MaxWeight(MaxWeight)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .req_i (req.payload),
    .stat_o(stat),
    .rsp_o (rsp.payload)
  );

endmodule
